### design/tlr_pkg.sv
// Shared types and constants for the timestamp linear resampler.
`default_nettype none
package tlr_pkg;

  localparam int unsigned TimeW = 63;
  localparam int unsigned PosW  = 32;
  localparam int unsigned SecW  = 32;
  localparam int unsigned UsecW = 20;
  localparam int unsigned ProdW = 97;
  localparam int unsigned QuoW  = 36;

  localparam logic [UsecW-1:0] UsecPerSec = 20'd1000000;
  localparam logic [6:0] MulSteps = 7'd32;
  localparam logic [6:0] DivSteps = 7'd96;
  localparam logic [36:0] QuoLimit = 37'h0_2_0000_0000;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_FLUSH  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TMUL,
    S_TADD,
    S_RD,
    S_CHK,
    S_SETUP,
    S_MUL,
    S_DIV,
    S_FIN,
    S_PUSH
  } state_e;

endpackage
`default_nettype wire

### design/timestamp_linear_resampler_unit.sv
// Top level of the timestamp linear resampler: sequencer, query queue and shared adder.
//
// Usage. Items enter on the in channel (valid/ready); cmd selects a reference
// sample, a query time or an end-of-stream flush. Results leave on the out
// channel (valid/ready) through one output register; last marks the final
// result caused by an input. The user must write base_time on the cfg channel
// only while the block is idle; the block itself does not enforce this.
// Throughput and datapath. The block takes one item at a time and is not ready
// while it works; a sample or a query is followed by the drain of the queue.
// Every interpolated result runs through one shared 98-bit adder: 33 shift-add
// multiply steps and 97 restoring divide steps. Waiting queries sit in a
// QUEUE_DEPTH circular buffer; a full queue returns one drop result (status 1)
// right away.
// Reset clears the sample state, the queue count and the output valid flag;
// queue storage is not cleared, no clearing pass is needed.
// When the receiver stalls, the finished result is held in the output
// register and the sequencer waits with the next result until it is taken.
`default_nettype none
module timestamp_linear_resampler_unit import tlr_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [TimeW-1:0]       cfg_data_i,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [1:0]             cmd_i,
  input  wire logic [SecW-1:0]        sample_seconds_i,
  input  wire logic signed [PosW-1:0] sample_position_i,
  input  wire logic [TimeW-1:0]       query_time_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic signed [PosW-1:0]      position_out_o,
  output logic [TimeW-1:0]            time_out_o,
  output logic                        status_o,
  output logic                        last_o
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] Full = CW'(QUEUE_DEPTH);
  localparam logic [AW-1:0] LastAddr = AW'(QUEUE_DEPTH - 1);

  state_e state_q, state_d;

  // Control state.
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] head_q, head_d, tail_q, tail_d;
  logic [1:0]    seen_q, seen_d;
  logic          flush_q, flush_d;
  logic          pend_q, pend_d;
  logic          out_valid_q, out_valid_d;
  logic [6:0]    cnt_q, cnt_d;

  // Datapath state.
  logic [TimeW-1:0]       base_q, base_d;
  logic [63:0]            older_t_q, older_t_d, newer_t_q, newer_t_d;
  logic signed [PosW-1:0] older_p_q, older_p_d, newer_p_q, newer_p_d;
  logic [SecW-1:0]        secs_q, secs_d;
  logic signed [PosW-1:0] spos_q, spos_d;
  logic [51:0]            tprod_q, tprod_d;
  logic [63:0]            dmag_q, dmag_d, emag_q, emag_d, rem_q, rem_d;
  logic [32:0]            pmag_q, pmag_d;
  logic                   neg_q, neg_d, ovf_q, ovf_d;
  logic [ProdW-1:0]       prod_q, prod_d;
  logic [QuoW-1:0]        quo_q, quo_d;
  logic signed [PosW-1:0] pend_p_q, pend_p_d, out_p_q, out_p_d;
  logic [TimeW-1:0]       pend_t_q, pend_t_d, out_t_q, out_t_d;
  logic                   pend_s_q, pend_s_d, out_s_q, out_s_d, out_l_q, out_l_d;

  // Query queue storage.
  logic [TimeW-1:0] mem_q [QUEUE_DEPTH];
  logic [TimeW-1:0] head_data_q;
  logic             mem_we;

  // Shared adder: multiply steps add, divide steps subtract.
  logic [ProdW-1:0] alu_a, alu_b;
  logic             alu_sub;
  logic [ProdW:0]   alu_y;

  // Setup values for one interpolation.
  logic [63:0] q_t, dmag_c, emag_c;
  logic        dneg_c, eneg_c, pneg_c;
  logic signed [32:0] dp_c;
  logic [32:0] pmag_c;

  logic        in_fire, slot_free, avail;
  logic        rnd;
  logic [36:0] qr;
  logic        sat;
  logic signed [34:0] sum;
  logic signed [PosW-1:0] fin_p;
  logic [63:0] t_new;

  assign in_fire   = in_valid_i && in_ready_o;
  assign slot_free = !out_valid_q || out_ready_i;
  assign q_t       = {1'b0, head_data_q};
  assign avail     = (count_q != '0) &&
                     (flush_q || ((seen_q != 2'd0) && (q_t <= newer_t_q)));
  assign t_new     = {12'd0, tprod_q} + {1'b0, base_q};

  always_comb begin
    dneg_c = newer_t_q < older_t_q;
    dmag_c = dneg_c ? older_t_q - newer_t_q : newer_t_q - older_t_q;
    eneg_c = q_t < older_t_q;
    emag_c = eneg_c ? older_t_q - q_t : q_t - older_t_q;
    dp_c   = 33'(newer_p_q) - 33'(older_p_q);
    pneg_c = dp_c[32];
    pmag_c = pneg_c ? 33'(-dp_c) : 33'(dp_c);
  end

  always_comb begin
    alu_sub = (state_q == S_DIV);
    if (alu_sub) begin
      alu_a = {32'd0, rem_q, prod_q[ProdW-1]};
      alu_b = {33'd0, dmag_q};
    end else begin
      alu_a = {prod_q[ProdW-2:0], 1'b0};
      alu_b = pmag_q[32] ? {33'd0, emag_q} : '0;
    end
    alu_y = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b}) : ({1'b0, alu_a} + {1'b0, alu_b});
  end

  // Rounding to nearest and saturation of the final sum.
  always_comb begin
    rnd = {rem_q, 1'b0} >= {1'b0, dmag_q};
    qr  = {1'b0, quo_q} + 37'(rnd);
    sat = ovf_q || (qr > QuoLimit);
    sum = neg_q ? 35'(older_p_q) - 35'(qr[33:0]) : 35'(older_p_q) + 35'(qr[33:0]);
    if (sat) begin
      fin_p = neg_q ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else if (sum > 35'sh0_7fff_ffff) begin
      fin_p = 32'sh7fff_ffff;
    end else if (sum < -35'sh0_8000_0000) begin
      fin_p = 32'sh8000_0000;
    end else begin
      fin_p = sum[31:0];
    end
  end

  // Sequencer: next state and datapath updates.
  always_comb begin
    state_d = state_q;     count_d = count_q;   head_d = head_q;   tail_d = tail_q;
    seen_d = seen_q;       flush_d = flush_q;   pend_d = pend_q;   cnt_d = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    base_d = base_q;       older_t_d = older_t_q; newer_t_d = newer_t_q;
    older_p_d = older_p_q; newer_p_d = newer_p_q; secs_d = secs_q; spos_d = spos_q;
    tprod_d = tprod_q;     dmag_d = dmag_q;     emag_d = emag_q;   rem_d = rem_q;
    pmag_d = pmag_q;       neg_d = neg_q;       ovf_d = ovf_q;     prod_d = prod_q;
    quo_d = quo_q;         pend_p_d = pend_p_q; pend_t_d = pend_t_q; pend_s_d = pend_s_q;
    out_p_d = out_p_q;     out_t_d = out_t_q;   out_s_d = out_s_q; out_l_d = out_l_q;
    mem_we = 1'b0;
    in_ready_o = (state_q == S_IDLE);

    if (cfg_valid_i) begin
      base_d = cfg_data_i;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          flush_d = 1'b0;
          case (cmd_i)
            CMD_SAMPLE: begin
              secs_d  = sample_seconds_i;
              spos_d  = sample_position_i;
              state_d = S_TMUL;
            end
            CMD_QUERY: begin
              if (count_q == Full) begin
                pend_d = 1'b1; pend_p_d = '0; pend_t_d = query_time_i; pend_s_d = 1'b1;
                state_d = S_CHK;
              end else begin
                mem_we  = 1'b1;
                tail_d  = (tail_q == LastAddr) ? '0 : tail_q + 1'b1;
                count_d = count_q + 1'b1;
                state_d = S_RD;
              end
            end
            CMD_FLUSH: begin
              flush_d = 1'b1;
              state_d = S_RD;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_TMUL: begin
        tprod_d = 52'(secs_q) * 52'(UsecPerSec);
        state_d = S_TADD;
      end
      S_TADD: begin
        if (seen_q == 2'd0) begin
          older_t_d = t_new;     older_p_d = spos_q;
        end else begin
          older_t_d = newer_t_q; older_p_d = newer_p_q;
        end
        newer_t_d = t_new;
        newer_p_d = spos_q;
        if (seen_q != 2'd2) begin
          seen_d = seen_q + 2'd1;
        end
        state_d = S_RD;
      end
      S_RD: begin
        state_d = S_CHK;
      end
      S_CHK: begin
        if (pend_q) begin
          state_d = S_PUSH;
        end else if (!avail) begin
          state_d = S_IDLE;
        end else if (flush_q) begin
          pend_d = 1'b1; pend_t_d = head_data_q; pend_s_d = 1'b0;
          pend_p_d = (seen_q != 2'd0) ? newer_p_q : '0;
          head_d = (head_q == LastAddr) ? '0 : head_q + 1'b1;
          count_d = count_q - 1'b1;
          state_d = S_RD;
        end else begin
          state_d = S_SETUP;
        end
      end
      S_SETUP: begin
        pend_t_d = head_data_q;
        pend_s_d = 1'b0;
        if ((newer_t_q == older_t_q) || (emag_c == '0) || (pmag_c == '0)) begin
          pend_d   = 1'b1;
          pend_p_d = (newer_t_q == older_t_q) ? newer_p_q : older_p_q;
          head_d = (head_q == LastAddr) ? '0 : head_q + 1'b1;
          count_d = count_q - 1'b1;
          state_d = S_RD;
        end else begin
          dmag_d = dmag_c; emag_d = emag_c; pmag_d = pmag_c;
          neg_d = pneg_c ^ eneg_c ^ dneg_c;
          prod_d = '0;
          cnt_d = MulSteps;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        prod_d = alu_y[ProdW-1:0];
        pmag_d = {pmag_q[31:0], 1'b0};
        if (cnt_q == '0) begin
          cnt_d = DivSteps; rem_d = '0; quo_d = '0; ovf_d = 1'b0;
          state_d = S_DIV;
        end else begin
          cnt_d = cnt_q - 7'd1;
        end
      end
      S_DIV: begin
        rem_d  = alu_y[ProdW] ? alu_a[63:0] : alu_y[63:0];
        quo_d  = {quo_q[QuoW-2:0], !alu_y[ProdW]};
        ovf_d  = ovf_q || quo_q[QuoW-1];
        prod_d = {prod_q[ProdW-2:0], 1'b0};
        if (cnt_q == '0) begin
          state_d = S_FIN;
        end else begin
          cnt_d = cnt_q - 7'd1;
        end
      end
      S_FIN: begin
        pend_d = 1'b1;
        pend_p_d = fin_p;
        head_d = (head_q == LastAddr) ? '0 : head_q + 1'b1;
        count_d = count_q - 1'b1;
        state_d = S_RD;
      end
      S_PUSH: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_p_d = pend_p_q; out_t_d = pend_t_q; out_s_d = pend_s_q;
          out_l_d = !avail;
          pend_d = 1'b0;
          state_d = S_CHK;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;   count_q <= '0;  head_q <= '0;  tail_q <= '0;
      seen_q <= 2'd0;      flush_q <= 1'b0; pend_q <= 1'b0;
      out_valid_q <= 1'b0; cnt_q <= '0;
      base_q <= '0;        older_t_q <= '0; newer_t_q <= '0;
      older_p_q <= '0;     newer_p_q <= '0;
    end else begin
      state_q <= state_d;  count_q <= count_d; head_q <= head_d; tail_q <= tail_d;
      seen_q <= seen_d;    flush_q <= flush_d; pend_q <= pend_d;
      out_valid_q <= out_valid_d; cnt_q <= cnt_d;
      base_q <= base_d;    older_t_q <= older_t_d; newer_t_q <= newer_t_d;
      older_p_q <= older_p_d; newer_p_q <= newer_p_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    secs_q <= secs_d;  spos_q <= spos_d;  tprod_q <= tprod_d;
    dmag_q <= dmag_d;  emag_q <= emag_d;  rem_q <= rem_d;  pmag_q <= pmag_d;
    neg_q <= neg_d;    ovf_q <= ovf_d;    prod_q <= prod_d; quo_q <= quo_d;
    pend_p_q <= pend_p_d; pend_t_q <= pend_t_d; pend_s_q <= pend_s_d;
    out_p_q <= out_p_d;   out_t_q <= out_t_d;   out_s_q <= out_s_d; out_l_q <= out_l_d;
  end

  // Queue memory: one write port at the tail, registered read of the head.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[tail_q] <= query_time_i;
    end
    head_data_q <= mem_q[head_q];
  end

  assign cfg_ready_o    = 1'b1;
  assign out_valid_o    = out_valid_q;
  assign position_out_o = out_p_q;
  assign time_out_o     = out_t_q;
  assign status_o       = out_s_q;
  assign last_o         = out_l_q;

endmodule
`default_nettype wire

### design/tlr_checker.sv
// Port-level checker for the resampler and its bind to the top level.
`default_nettype none
module tlr_checker import tlr_pkg::*; (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   in_valid_i,
  input wire logic                   in_ready_o,
  input wire logic [1:0]             cmd_i,
  input wire logic                   out_valid_o,
  input wire logic                   out_ready_i,
  input wire logic signed [PosW-1:0] position_out_o,
  input wire logic                   status_o,
  input wire logic                   last_o
);

  // A stalled result keeps its position.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(position_out_o))
    else $error("stalled result changed");

  // A dropped query is answered alone, with position zero.
  a_drop_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> last_o && (position_out_o == '0))
    else $error("malformed drop result");

  // A sample transfer keeps the block busy for the time computation.
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (cmd_i == CMD_SAMPLE) |=> !in_ready_o)
    else $error("ready right after a sample");

endmodule

bind timestamp_linear_resampler_unit tlr_checker u_tlr_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
  .cmd_i(cmd_i), .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
  .position_out_o(position_out_o), .status_o(status_o), .last_o(last_o)
);
`default_nettype wire
